// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/cldr_pkg.sv
// Types and constants of the character LCD refresh block.
package cldr_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 16;
    localparam int DELAY_W = 8;

    localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'h20;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd37;

    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic CMD_POS  = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    typedef struct packed {
        logic store;
        logic commit;
        logic clr_pending;
        logic scan_start;
        logic rd_cur;
        logic acc_add;
        logic write_char;
        logic out_load;
        logic out_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pending;
        logic scan_done;
        logic scan_hit;
        logic cur_dirty;
        logic acc_met;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/char_lcd_dirty_refresh.sv
// Top level of the character LCD dirty-cell refresh block.
// Store, commit and unknown transactions do not stall; a tick in wait goes through S_WCHK,
// one in write waits in S_WRC for a free output register. A tick that scans for a dirty cell
// reads one cell per cycle, then on a hit waits in S_POS to load a set-position result.
// One transaction is in work at a time; the output register holds a result while the next is taken.
// Reset is asynchronous; buffers read as spaces through per-cell valid bits, no clearing pass.
module char_lcd_dirty_refresh #(
    parameter int ROWS  = 2,
    parameter int WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic                         cell_row,
    input  logic [3:0]                   cell_col,
    input  logic [cldr_pkg::CHAR_W-1:0]  char_value,
    input  logic [cldr_pkg::ACC_W-1:0]   tick_us,
    input  logic                         cfg_wr_en,
    input  logic [cldr_pkg::DELAY_W-1:0] cfg_wr_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         cmd_kind,
    output logic                         cmd_row,
    output logic [3:0]                   cmd_col,
    output logic [cldr_pkg::CHAR_W-1:0]  cmd_char
);
    import cldr_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    cldr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    cldr_datapath #(
        .ROWS  (ROWS),
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctrl_cmd),
        .stat        (dp_stat),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .char_value  (char_value),
        .tick_us     (tick_us),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .cmd_kind    (cmd_kind),
        .cmd_row     (cmd_row),
        .cmd_col     (cmd_col),
        .cmd_char    (cmd_char)
    );

endmodule

// File: hdl/cldr_datapath.sv
// Datapath: target and shadow buffers, dirty scan, cursor, wait accumulator, output register.
module cldr_datapath #(
    parameter int ROWS  = 2,
    parameter int WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cldr_pkg::ctrl_cmd_t         cmd,
    output cldr_pkg::dp_stat_t          stat,
    input  logic                        cell_row,
    input  logic [3:0]                  cell_col,
    input  logic [cldr_pkg::CHAR_W-1:0] char_value,
    input  logic [cldr_pkg::ACC_W-1:0]  tick_us,
    input  logic                        cfg_wr_en,
    input  logic [cldr_pkg::DELAY_W-1:0] cfg_wr_data,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic                        cmd_kind,
    output logic                        cmd_row,
    output logic [3:0]                  cmd_col,
    output logic [cldr_pkg::CHAR_W-1:0] cmd_char
);
    import cldr_pkg::*;

    localparam int CELLS  = ROWS * WIDTH;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = $clog2(WIDTH + 1);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] r,
                                                  input logic [ADDR_W-1:0] c);
        logic [ADDR_W-1:0] a;
        a = r * ADDR_W'(WIDTH) + c;
        return a;
    endfunction

    logic [CHAR_W-1:0] tgt_mem [CELLS];
    logic [CHAR_W-1:0] shd_mem [CELLS];
    logic [CELLS-1:0]  tgt_vld_reg;
    logic [CELLS-1:0]  shd_vld_reg;
    logic [CHAR_W-1:0] tgt_q_reg;
    logic [CHAR_W-1:0] shd_q_reg;
    logic              tgt_vq_reg;
    logic              shd_vq_reg;
    logic              rd_inrange_reg;

    logic [ROW_W-1:0]  cur_row_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  scan_row_reg;
    logic [COL_W-1:0]  scan_col_reg;
    logic [ROW_W-1:0]  cmp_row_reg;
    logic [COL_W-1:0]  cmp_col_reg;
    logic              scan_act_reg;
    logic              cmp_v_reg;
    logic              done_reg;
    logic              hit_reg;

    logic              pending_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DELAY_W-1:0] delay_reg;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic              out_row_reg;
    logic [3:0]        out_col_reg;
    logic [CHAR_W-1:0] out_char_reg;

    logic [CHAR_W-1:0] tgt_eff;
    logic [CHAR_W-1:0] shd_eff;
    logic [CHAR_W-1:0] wr_char;
    logic [CHAR_W-1:0] store_char;
    logic [ADDR_W-1:0] store_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] scan_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              store_we;
    logic              cur_in_range;
    logic              rd_en;
    logic              shd_we;
    logic              cmp_dirty;
    logic              scan_last;
    logic              hit_now;
    logic              out_free;
    logic [ACC_W:0]    acc_sum;

    assign tgt_eff    = tgt_vq_reg ? tgt_q_reg : SPACE_CHAR;
    assign shd_eff    = shd_vq_reg ? shd_q_reg : SPACE_CHAR;
    assign cmp_dirty  = (tgt_eff != shd_eff);
    assign wr_char    = rd_inrange_reg ? tgt_eff : SPACE_CHAR;

    assign store_char = (char_value == '0) ? SPACE_CHAR : char_value;
    assign store_addr = addr_of(ADDR_W'(cell_row), ADDR_W'(cell_col));
    assign store_we   = cmd.store && (int'(cell_row) < ROWS) && (int'(cell_col) < WIDTH);

    assign cur_in_range = (int'(cur_row_reg) < ROWS) && (int'(cur_col_reg) < WIDTH);
    assign cur_addr     = addr_of(ADDR_W'(cur_row_reg), ADDR_W'(cur_col_reg));
    assign scan_addr    = addr_of(ADDR_W'(scan_row_reg), ADDR_W'(scan_col_reg));
    assign rd_addr      = scan_act_reg ? scan_addr : cur_addr;
    assign rd_en        = scan_act_reg || (cmd.rd_cur && cur_in_range);
    assign shd_we       = cmd.write_char && rd_inrange_reg;

    assign scan_last = (int'(scan_row_reg) == ROWS - 1) && (int'(scan_col_reg) == WIDTH - 1);
    assign hit_now   = cmp_v_reg && cmp_dirty && !cmd.scan_start;

    assign out_free = !out_valid_reg || !out_stall;
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, tick_us};

    // Buffer storage
    always_ff @(posedge clk)
    begin
        if (store_we)
            tgt_mem[store_addr] <= store_char;
        if (shd_we)
            shd_mem[cur_addr] <= wr_char;
        if (rd_en)
        begin
            tgt_q_reg <= tgt_mem[rd_addr];
            shd_q_reg <= shd_mem[rd_addr];
        end
    end

    // Valid bits: an unwritten cell reads as a space
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_vld_reg    <= '0;
            shd_vld_reg    <= '0;
            tgt_vq_reg     <= 1'b0;
            shd_vq_reg     <= 1'b0;
            rd_inrange_reg <= 1'b0;
        end
        else
        begin
            if (store_we)
                tgt_vld_reg[store_addr] <= 1'b1;
            if (shd_we)
                shd_vld_reg[cur_addr] <= 1'b1;
            if (rd_en)
            begin
                tgt_vq_reg <= tgt_vld_reg[rd_addr];
                shd_vq_reg <= shd_vld_reg[rd_addr];
            end
            if (cmd.rd_cur)
                rd_inrange_reg <= cur_in_range;
        end
    end

    // Dirty scan: issue one cell per cycle, compare its registered read in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_act_reg <= 1'b0;
            scan_row_reg <= '0;
            scan_col_reg <= '0;
            cmp_v_reg    <= 1'b0;
            cmp_row_reg  <= '0;
            cmp_col_reg  <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_act_reg <= 1'b1;
            scan_row_reg <= '0;
            scan_col_reg <= '0;
            cmp_v_reg    <= 1'b0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= scan_act_reg;
            if (scan_act_reg)
            begin
                cmp_row_reg <= scan_row_reg;
                cmp_col_reg <= scan_col_reg;
                if (int'(scan_col_reg) == WIDTH - 1)
                begin
                    scan_col_reg <= '0;
                    scan_row_reg <= scan_row_reg + ROW_W'(1);
                end
                else
                begin
                    scan_col_reg <= scan_col_reg + COL_W'(1);
                end
                if (scan_last)
                    scan_act_reg <= 1'b0;
            end
            if (hit_now)
            begin
                hit_reg      <= 1'b1;
                done_reg     <= 1'b1;
                scan_act_reg <= 1'b0;
                cmp_v_reg    <= 1'b0;
            end
            else if (cmp_v_reg && !scan_act_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Cursor, request flag, wait accumulator, delay register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            pending_reg <= 1'b0;
            acc_reg     <= '0;
            delay_reg   <= DELAY_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            else if (hit_now)
            begin
                cur_row_reg <= cmp_row_reg;
                cur_col_reg <= cmp_col_reg;
            end
            else if (cmd.write_char)
            begin
                cur_col_reg <= cur_col_reg + COL_W'(1);
            end

            if (cmd.commit)
                pending_reg <= 1'b1;
            else if (cmd.clr_pending)
                pending_reg <= 1'b0;

            if (cmd.write_char)
                acc_reg <= '0;
            else if (cmd.acc_add)
                acc_reg <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

            if (cfg_wr_en)
                delay_reg <= cfg_wr_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            if (cmd.out_kind == CMD_POS)
            begin
                out_row_reg  <= cur_row_reg[0];
                out_col_reg  <= cur_col_reg[3:0];
                out_char_reg <= '0;
            end
            else
            begin
                out_row_reg  <= 1'b0;
                out_col_reg  <= '0;
                out_char_reg <= wr_char;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd_kind  = out_kind_reg;
    assign cmd_row   = out_row_reg;
    assign cmd_col   = out_col_reg;
    assign cmd_char  = out_char_reg;

    assign stat.pending   = pending_reg;
    assign stat.scan_done = done_reg;
    assign stat.scan_hit  = hit_reg;
    assign stat.cur_dirty = rd_inrange_reg && cmp_dirty;
    assign stat.acc_met   = (acc_reg >= ACC_W'(delay_reg));
    assign stat.out_free  = out_free;

endmodule

// File: hdl/cldr_ctrl.sv
// Controller: refresh state machine and per-transaction sequencer.
module cldr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          kind,
    output logic                in_stall,
    input  cldr_pkg::dp_stat_t  stat,
    output cldr_pkg::ctrl_cmd_t cmd
);
    import cldr_pkg::*;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_WRITE = 2'd1;
    localparam logic [1:0] F_WAIT  = 2'd2;
    localparam logic [1:0] F_FIND  = 2'd3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WCHK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POS  = 3'd3;
    localparam logic [2:0] S_WRC  = 3'd4;

    logic [1:0] fsm_reg;
    logic [1:0] fsm_next;
    logic [2:0] seq_reg;
    logic [2:0] seq_next;
    logic       accept;

    assign in_stall = (seq_reg != S_IDLE);
    assign accept   = in_valid && (seq_reg == S_IDLE);

    always_comb
    begin
        cmd      = '0;
        fsm_next = fsm_reg;
        seq_next = seq_reg;
        case (seq_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_STORE:  cmd.store  = 1'b1;
                        KIND_COMMIT: cmd.commit = 1'b1;
                        KIND_TICK:
                        begin
                            case (fsm_reg)
                                F_IDLE:
                                begin
                                    if (stat.pending)
                                    begin
                                        cmd.clr_pending = 1'b1;
                                        cmd.scan_start  = 1'b1;
                                        seq_next        = S_SCAN;
                                    end
                                end
                                F_WRITE:
                                begin
                                    cmd.rd_cur = 1'b1;
                                    seq_next   = S_WRC;
                                end
                                F_WAIT:
                                begin
                                    cmd.acc_add = 1'b1;
                                    cmd.rd_cur  = 1'b1;
                                    seq_next    = S_WCHK;
                                end
                                F_FIND:
                                begin
                                    cmd.scan_start = 1'b1;
                                    seq_next       = S_SCAN;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_WCHK:
            begin
                if (stat.acc_met)
                    fsm_next = stat.cur_dirty ? F_WRITE : F_FIND;
                seq_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.scan_hit)
                    begin
                        fsm_next = F_WRITE;
                        seq_next = S_POS;
                    end
                    else
                    begin
                        fsm_next = F_IDLE;
                        seq_next = S_IDLE;
                    end
                end
            end
            S_POS:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = CMD_POS;
                    seq_next     = S_IDLE;
                end
            end
            S_WRC:
            begin
                if (stat.out_free)
                begin
                    cmd.write_char = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = CMD_CHAR;
                    fsm_next       = F_WAIT;
                    seq_next       = S_IDLE;
                end
            end
            default: seq_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg <= F_IDLE;
            seq_reg <= S_IDLE;
        end
        else
        begin
            fsm_reg <= fsm_next;
            seq_reg <= seq_next;
        end
    end

endmodule

// File: hdl/cldr_checker.sv
// Port-level assertions for the refresh block, bound to the top level.
`include "assert_macros.svh"

module cldr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [1:0]                   kind,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         cmd_kind,
    input logic                         cmd_row,
    input logic [3:0]                   cmd_col,
    input logic [cldr_pkg::CHAR_W-1:0]  cmd_char
);
    import cldr_pkg::*;

    logic [CHAR_W+5:0] out_bits;
    logic              pos_out;
    logic              char_out;

    assign out_bits = {cmd_kind, cmd_row, cmd_col, cmd_char};
    assign pos_out  = out_valid && (cmd_kind == CMD_POS);
    assign char_out = out_valid && (cmd_kind == CMD_CHAR);

    // Held result keeps its fields
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bits))

    // Position commands carry no character
    `ASSERT_IMPL(a_pos_no_char, clk, rst_n, pos_out, cmd_char == '0)

    // Character commands carry no cursor
    `ASSERT_IMPL(a_char_no_pos, clk, rst_n, char_out, !cmd_row && cmd_col == '0)

    // Non-tick transactions do not raise the input stall
    `ASSERT_NEXT(a_non_tick_fast, clk, rst_n, in_valid && !in_stall && kind != KIND_TICK, !in_stall)

endmodule

bind char_lcd_dirty_refresh cldr_checker u_checker (.*);

// File: tb/sv/tb_char_lcd_dirty_refresh.sv
// Self-checking testbench of the character LCD dirty-cell refresh block.
module tb_char_lcd_dirty_refresh;
    timeunit 1ns;
    timeprecision 1ps;

    import cldr_pkg::*;

    localparam int ROWS = 2;
    localparam int WIDTH = 16;
    localparam int CELLS = ROWS * WIDTH;
    localparam int ACC_MAX = 65535;
    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int SETTLE_CYCLES = CELLS + 8;
    localparam int PHASE_ITEMS = 350;
    localparam int STAGE_LEN = 467;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_WAIT,
        S_SCAN
    } fsm_t;

    typedef struct packed {
        logic       kind;
        logic       row;
        logic [3:0] col;
        logic [7:0] code;
    } lcd_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        row;
        logic [3:0]  col;
        logic [7:0]  ch;
        logic [15:0] el;
        bit          typed;
        lcd_cmd_t    cmd;
    } plan_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic        cell_row = 1'b0;
    logic [3:0]  cell_col = '0;
    logic [7:0]  char_value = '0;
    logic [15:0] tick_us = '0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        cmd_kind;
    logic        cmd_row;
    logic [3:0]  cmd_col;
    logic [7:0]  cmd_char;

    // predictor state
    logic [7:0] tgt_cells [CELLS];
    logic [7:0] shd_cells [CELLS];
    fsm_t       fsm = S_IDLE;
    bit         req_pending = 1'b0;
    int         row_ptr = 0;
    int         col_ptr = 0;
    int         acc_us = 0;
    logic [7:0] delay_us = DELAY_RESET;

    lcd_cmd_t  due_cmds [$];
    plan_row_t script [$];

    int fail_cnt = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 27;
    int recv_idle_pct = 73;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    char_lcd_dirty_refresh #(
        .ROWS  (ROWS),
        .WIDTH (WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .char_value  (char_value),
        .tick_us     (tick_us),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd_kind    (cmd_kind),
        .cmd_row     (cmd_row),
        .cmd_col     (cmd_col),
        .cmd_char    (cmd_char)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit cell_differs(input int r, input int c);
        if (r >= ROWS || c >= WIDTH)
            return 1'b0;
        return tgt_cells[r * WIDTH + c] != shd_cells[r * WIDTH + c];
    endfunction

    function automatic bit seek_dirty();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < WIDTH; c++)
                if (cell_differs(r, c))
                begin
                    row_ptr = r;
                    col_ptr = c;
                    return 1'b1;
                end
        return 1'b0;
    endfunction

    function automatic lcd_cmd_t pos_cmd();
        lcd_cmd_t cmd;
        cmd = '0;
        cmd.kind = CMD_POS;
        cmd.row = row_ptr[0];
        cmd.col = col_ptr[3:0];
        return cmd;
    endfunction

    // Advances the refresh state by one transaction; returns 1 when a command comes out.
    function automatic bit lcd_refresh_step(input plan_row_t it, output lcd_cmd_t cmd);
        logic [7:0] code;
        int idx;
        cmd = '0;
        case (it.kind)
            KIND_STORE:
            begin
                if (int'(it.row) < ROWS && int'(it.col) < WIDTH)
                    tgt_cells[int'(it.row) * WIDTH + int'(it.col)] =
                        (it.ch == 8'd0) ? SPACE_CHAR : it.ch;
            end
            KIND_COMMIT:
            begin
                req_pending = 1'b1;
                row_ptr = 0;
                col_ptr = 0;
            end
            KIND_TICK:
            begin
                case (fsm)
                    S_IDLE:
                    begin
                        if (req_pending)
                        begin
                            req_pending = 1'b0;
                            if (seek_dirty())
                            begin
                                fsm = S_WRITE;
                                cmd = pos_cmd();
                                return 1'b1;
                            end
                        end
                    end
                    S_WRITE:
                    begin
                        code = SPACE_CHAR;
                        if (row_ptr < ROWS && col_ptr < WIDTH)
                        begin
                            idx = row_ptr * WIDTH + col_ptr;
                            code = tgt_cells[idx];
                            shd_cells[idx] = code;
                        end
                        col_ptr++;
                        acc_us = 0;
                        fsm = S_WAIT;
                        cmd.kind = CMD_CHAR;
                        cmd.code = code;
                        return 1'b1;
                    end
                    S_WAIT:
                    begin
                        acc_us += int'(it.el);
                        if (acc_us > ACC_MAX)
                            acc_us = ACC_MAX;
                        if (acc_us >= int'(delay_us))
                        begin
                            if (cell_differs(row_ptr, col_ptr))
                                fsm = S_WRITE;
                            else
                                fsm = S_SCAN;
                        end
                    end
                    default:
                    begin
                        if (seek_dirty())
                        begin
                            fsm = S_WRITE;
                            cmd = pos_cmd();
                            return 1'b1;
                        end
                        fsm = S_IDLE;
                    end
                endcase
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic plan_row_t step_row(input logic [1:0] k, input logic r,
                                           input logic [3:0] c, input logic [7:0] ch,
                                           input logic [15:0] el);
        plan_row_t it;
        it = '0;
        it.kind = k;
        it.row = r;
        it.col = c;
        it.ch = ch;
        it.el = el;
        return it;
    endfunction

    function automatic plan_row_t typed_row(input plan_row_t it, input logic k, input logic r,
                                            input logic [3:0] c, input logic [7:0] code);
        plan_row_t res;
        res = it;
        res.typed = 1'b1;
        res.cmd.kind = k;
        res.cmd.row = r;
        res.cmd.col = c;
        res.cmd.code = code;
        return res;
    endfunction

    function automatic plan_row_t rand_item();
        plan_row_t it;
        int pick;
        it = '0;
        pick = $urandom_range(99);
        if (pick < 55)
            it.kind = KIND_TICK;
        else if (pick < 85)
            it.kind = KIND_STORE;
        else if (pick < 96)
            it.kind = KIND_COMMIT;
        else
            it.kind = KIND_NOP;
        it.row = 1'($urandom_range(1));
        it.col = ($urandom_range(99) < 40) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 10)
            it.ch = 8'd0;
        else if (pick < 25)
            it.ch = SPACE_CHAR;
        else
            it.ch = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 20)
            it.el = 16'd0;
        else if (pick < 55)
            it.el = 16'($urandom_range(40));
        else if (pick < 85)
            it.el = 16'($urandom_range(400));
        else
            it.el = 16'($urandom_range(65535));
        return it;
    endfunction

    task automatic send_item(input plan_row_t it);
        lcd_cmd_t cmd;
        bit got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= it.kind;
        cell_row <= it.row;
        cell_col <= it.col;
        char_value <= it.ch;
        tick_us <= it.el;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = lcd_refresh_step(it, cmd);
        if (it.typed)
            due_cmds.push_back(it.cmd);
        else if (got)
            due_cmds.push_back(cmd);
    endtask

    // scan passes may still run after the last command; let them finish
    task automatic settle();
        in_valid <= 1'b0;
        while (due_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_delay(input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        delay_us = v;
    endtask

    always @(posedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        lcd_cmd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_cmds.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("unexpected command: kind %0d row %0d col %0d code %02h",
                             cmd_kind, cmd_row, cmd_col, cmd_char);
            end
            else
            begin
                want = due_cmds.pop_front();
                if (want.kind !== cmd_kind || want.row !== cmd_row ||
                    want.col !== cmd_col || want.code !== cmd_char)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("command mismatch: expected %0d/%0d/%0d/%02h got %0d/%0d/%0d/%02h",
                                 want.kind, want.row, want.col, want.code,
                                 cmd_kind, cmd_row, cmd_col, cmd_char);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** char_lcd_dirty_refresh: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int sent;
        plan_row_t it;
        logic [7:0] phase_delay [4];

        for (int i = 0; i < CELLS; i++)
        begin
            tgt_cells[i] = SPACE_CHAR;
            shd_cells[i] = SPACE_CHAR;
        end
        phase_delay[0] = 8'd0;
        phase_delay[1] = 8'd255;
        phase_delay[2] = 8'd1;
        phase_delay[3] = 8'($urandom_range(2, 254));

        // idle tick, request on clean buffers, zero stored as space
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0));
        script.push_back(step_row(KIND_COMMIT, 1'b1, 4'd15, 8'hFF, 16'hFFFF));
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0));
        script.push_back(step_row(KIND_STORE, 1'b0, 4'd0, 8'h00, 16'd0));
        script.push_back(step_row(KIND_COMMIT, 1'b0, 4'd0, 8'h00, 16'd0));
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0));
        // edge cells, unknown kind with all fields but the character high
        script.push_back(step_row(KIND_STORE, 1'b1, 4'd15, 8'hFF, 16'd0));
        script.push_back(step_row(KIND_STORE, 1'b0, 4'd15, 8'h01, 16'hFFFF));
        script.push_back(step_row(KIND_NOP, 1'b1, 4'd15, 8'hAA, 16'hFFFF));
        script.push_back(step_row(KIND_COMMIT, 1'b0, 4'd0, 8'h00, 16'd0));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_POS, 1'b0, 4'd15, 8'h00));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b1, 4'd9, 8'h55, 16'hFFFF),
                                   CMD_CHAR, 1'b0, 4'd0, 8'h01));
        // one short of the delay, then saturation
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd36));
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'hFFFF));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_POS, 1'b1, 4'd15, 8'h00));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_CHAR, 1'b0, 4'd0, 8'hFF));
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd37));
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0));
        // commit during a write restarts at the first cell
        script.push_back(step_row(KIND_STORE, 1'b0, 4'd3, 8'h41, 16'd0));
        script.push_back(step_row(KIND_STORE, 1'b0, 4'd4, 8'h42, 16'd0));
        script.push_back(step_row(KIND_COMMIT, 1'b0, 4'd0, 8'h00, 16'd0));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_POS, 1'b0, 4'd3, 8'h00));
        script.push_back(step_row(KIND_COMMIT, 1'b0, 4'd0, 8'h00, 16'd0));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_CHAR, 1'b0, 4'd0, SPACE_CHAR));
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'hFFFF));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_POS, 1'b0, 4'd3, 8'h00));
        // run along the row without a new position
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_CHAR, 1'b0, 4'd0, 8'h41));
        script.push_back(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd40));
        script.push_back(typed_row(step_row(KIND_TICK, 1'b0, 4'd0, 8'h00, 16'd0),
                                   CMD_CHAR, 1'b0, 4'd0, 8'h42));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i]);

        sent = 0;
        for (int p = 0; p < 4; p++)
        begin
            settle();
            write_delay(phase_delay[p]);
            for (int n = 0; n < PHASE_ITEMS; )
            begin
                if (sent == STAGE_LEN)
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 27;
                end
                if (sent == 2 * STAGE_LEN)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_armed = 1'b1;
                end
                it = rand_item();
                send_item(it);
                if (it.kind != KIND_NOP)
                begin
                    n++;
                    sent++;
                end
            end
        end

        settle();
        if (due_cmds.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("** char_lcd_dirty_refresh: PASSED **");
        else
            $display("** char_lcd_dirty_refresh: FAILED **");
        $finish;
    end

endmodule
